// ===== rtl/sctd_pkg.sv =====
`timescale 1ns / 1ps

package sctd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned TempW   = 18;
  localparam int unsigned QuoW    = 2 * ByteW;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned StepW   = $clog2(DivSteps);

  // Job queue between front and back
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Scratchpad byte positions
  localparam logic [PosW-1:0] PosTempLsb  = 4'd0;
  localparam logic [PosW-1:0] PosTempMsb  = 4'd1;
  localparam logic [PosW-1:0] PosCountRem = 4'd6;
  localparam logic [PosW-1:0] PosCountPer = 4'd7;
  localparam logic [PosW-1:0] PosLast     = 4'd8;

  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;
  localparam logic [TempW-1:0] QuarterQ8 = 18'd64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_CRC_ERR   = 2'd2,
    ST_CPC_ZERO  = 2'd3
  } status_e;

  // One classified scratchpad block, handed from front to back
  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] whole;  // signed whole degrees
    logic             neg;    // count remaining above count per degree
    logic [ByteW-1:0] mag;    // |cpc - cr|
    logic [ByteW-1:0] cpc;
  } job_t;

  // Reflected 1-Wire CRC8 over one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/scratchpad_crc_temperature_decode.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Beat payload
// -------   --------------------   ------------------------------------------
// in        push   / full          data_byte_i (scratchpad byte 0..8 in order)
// out       pop    / empty         status_o, temperature_q8_o (one per block)
//
// The front takes one byte per cycle; full rises only on the ninth byte of
// a block while the two-entry job queue is full.
// The back takes a job in its idle state, runs the shift-subtract divider for
// the fraction, then loads the result register in its output state; a job
// with an error status skips the divider.
// Reset is asynchronous and active low; it clears the byte position, CRC,
// queue pointers, back state and the result valid flag.
// A result left unpopped holds the back in its output state; bytes keep
// flowing until the queue fills.

module scratchpad_crc_temperature_decode import sctd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [ByteW-1:0]        data_byte_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status_o,
  output logic signed [TempW-1:0] temperature_q8_o
);

  // Job handoff between front and back
  job_t front_job, back_job;
  logic jq_push, jq_full, jq_pop, jq_empty;

  // Front: accept bytes, run the CRC, latch fields, classify on the last byte
  sctd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .data_byte_i (data_byte_i),
    .job_push_o  (jq_push),
    .job_o       (front_job),
    .job_full_i  (jq_full)
  );

  // Decouple: hold classified blocks while the back is dividing
  sctd_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .job_i   (front_job),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .job_o   (back_job),
    .empty_o (jq_empty)
  );

  // Back: divide the count fraction, assemble Q8 temperature, drive result beat
  sctd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (back_job),
    .job_empty_i      (jq_empty),
    .job_pop_o        (jq_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .status_o         (status_o),
    .temperature_q8_o (temperature_q8_o)
  );

endmodule

// ===== rtl/sctd_front.sv =====
`timescale 1ns / 1ps

module sctd_front import sctd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             job_push_o,
  output job_t             job_o,
  input  logic             job_full_i
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d, crc_next;
  logic [ByteW-1:0] half_q, cr_q, cpc_q;
  logic             sign_q;
  logic             accept;
  logic             last_byte;
  logic [ByteW:0]   cr_plus1;

  assign last_byte = (pos_q == PosLast);
  assign full_o    = last_byte && job_full_i;
  assign accept    = push_i && !full_o;
  assign crc_next  = crc8_byte(crc_q, data_byte_i);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept) begin
      if (last_byte) begin
        pos_d = '0;
        crc_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        crc_d = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= '0;
      half_q <= '0;
      sign_q <= 1'b0;
      cr_q   <= '0;
      cpc_q  <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      if (accept) begin
        case (pos_q)
          PosTempLsb:  half_q <= data_byte_i;
          PosTempMsb:  sign_q <= data_byte_i[0];
          PosCountRem: cr_q   <= data_byte_i;
          PosCountPer: cpc_q  <= data_byte_i;
          default: ;
        endcase
      end
    end
  end

  // Classify the block on its ninth byte
  assign cr_plus1   = {1'b0, cr_q} + 1'b1;
  assign job_push_o = accept && last_byte;

  always_comb begin
    job_o.whole = {sign_q, half_q[ByteW-1:1]};
    job_o.neg   = (cr_q > cpc_q);
    job_o.mag   = job_o.neg ? (cr_q - cpc_q) : (cpc_q - cr_q);
    job_o.cpc   = cpc_q;
    if (crc_next != '0) begin
      job_o.status = ST_CRC_ERR;
    end else if ({1'b0, cpc_q} == cr_plus1) begin
      job_o.status = ST_NOT_READY;
    end else if (cpc_q == '0) begin
      job_o.status = ST_CPC_ZERO;
    end else begin
      job_o.status = ST_OK;
    end
  end

endmodule

// ===== rtl/sctd_jobq.sv =====
`timescale 1ns / 1ps

module sctd_jobq import sctd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sctd_back.sv =====
`timescale 1ns / 1ps

module sctd_back import sctd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  job_t                    job_i,
  input  logic                    job_empty_i,
  output logic                    job_pop_o,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [1:0]              status_o,
  output logic signed [TempW-1:0] temperature_q8_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } bstate_e;

  bstate_e          state_q, state_d;
  job_t             job_q;
  logic [StepW-1:0] step_q;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [ByteW:0]   rem_sh;
  logic             ge;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [TempW-1:0] out_temp_q;
  logic [TempW-1:0] frac, frac_s, temp_d;
  logic             out_load;

  // One restoring division step: remainder stays below cpc
  assign rem_sh = {rem_q, quo_q[QuoW-1]};
  assign ge     = (rem_sh >= {1'b0, job_q.cpc});
  assign rem_d  = ge ? ByteW'(rem_sh - {1'b0, job_q.cpc}) : rem_sh[ByteW-1:0];
  assign quo_d  = {quo_q[QuoW-2:0], ge};

  assign frac   = {{(TempW - QuoW){1'b0}}, quo_q};
  assign frac_s = job_q.neg ? (~frac + 1'b1) : frac;

  always_comb begin
    if (job_q.status == ST_OK) begin
      temp_d = {{(TempW - 2 * ByteW){job_q.whole[ByteW-1]}}, job_q.whole, {ByteW{1'b0}}}
               - QuarterQ8 + frac_s;
    end else begin
      temp_d = '0;
    end
  end

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign out_load  = (state_q == B_OUT) && (!out_valid_q || pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          state_d = (job_i.status == ST_OK) ? B_DIV : B_OUT;
        end
      end
      B_DIV: begin
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (out_load) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      rem_q <= '0;
      quo_q <= {job_i.mag, {ByteW{1'b0}}};
    end else if (state_q == B_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (out_load) begin
      out_status_q <= job_q.status;
      out_temp_q   <= temp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o          = !out_valid_q;
  assign status_o         = out_status_q;
  assign temperature_q8_o = out_temp_q;

endmodule

// ===== rtl/sctd_checker.sv =====
`timescale 1ns / 1ps

module sctd_checker import sctd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    empty,
  input logic                    pop,
  input logic [1:0]              status_o,
  input logic signed [TempW-1:0] temperature_q8_o
);

  // A waiting result beat holds until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(temperature_q8_o)))
    else $error("result beat changed while stalled");

  // Error statuses carry a zero temperature
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != ST_OK)) |-> (temperature_q8_o == '0))
    else $error("nonzero temperature with error status");

  // Ok temperatures stay inside the reachable range
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == ST_OK)) |->
      ((temperature_q8_o >= -18'sd97856) && (temperature_q8_o <= 18'sd32704)))
    else $error("temperature out of range");

endmodule

bind scratchpad_crc_temperature_decode sctd_checker u_sctd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .status_o         (status_o),
  .temperature_q8_o (temperature_q8_o)
);

// ===== dv/scratchpad_crc_temperature_decode_tb.sv =====
`timescale 1ns / 1ps

module scratchpad_crc_temperature_decode_tb;
  import sctd_pkg::*;

  // Hard stop, far above the slowest legal run with the idle patterns below
  localparam int unsigned CycleLimit = 300000;
  // Scratchpad blocks cover bytes 0..8; the random part stops after this many bytes
  localparam int unsigned ByteBudget = 600;
  // Drain time after the last pending reading, padded past the ok path
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    status_e                 status;
    logic signed [TempW-1:0] temp;
  } reading_t;

  // One directed block: bytes 0..7 (byte 0 in the top byte), CRC appended by
  // the bench. A flipped bit makes the CRC fail; typed rows carry the answer.
  typedef struct packed {
    logic [63:0]             body;
    logic                    bad_crc;
    logic                    typed;
    status_e                 status;
    logic signed [TempW-1:0] temp;
  } scratch_row_t;

  localparam int unsigned DirRows = 6;

  scratch_row_t dir_rows [DirRows] = '{
    // warmest reading: whole 127, full positive fraction, byte extremes 00/FF
    '{64'hFF00_00FF_7FFF_00FF, 1'b0, 1'b1, ST_OK,        18'sd32704},
    // coldest reading: sign set, count remaining far above count per degree
    '{64'h0001_4B46_7FFF_FF01, 1'b0, 1'b1, ST_OK,        -18'sd97856},
    // count per degree exactly one above count remaining
    '{64'h2A00_4B46_7FFF_0F10, 1'b0, 1'b1, ST_NOT_READY, 18'sd0},
    // zero count per degree
    '{64'h3200_4B46_7FFF_FF00, 1'b0, 1'b1, ST_CPC_ZERO,  18'sd0},
    // bad CRC wins over not ready
    '{64'h2A00_4B46_7FFF_0F10, 1'b1, 1'b1, ST_CRC_ERR,   18'sd0},
    // negative fraction, sign set through bit 0 only
    '{64'hAAFF_4B46_7FFF_1110, 1'b0, 1'b0, ST_OK,        18'sd0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic [ByteW-1:0]        data_byte_i;
  logic                    empty;
  logic                    pop;
  logic [1:0]              status_o;
  logic signed [TempW-1:0] temperature_q8_o;

  scratchpad_crc_temperature_decode i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .temperature_q8_o (temperature_q8_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Decoder shadow state, advanced once per accepted beat
  logic [PosW-1:0]  scratch_pos;
  logic [ByteW-1:0] scratch_crc;
  logic [ByteW-1:0] temp_half;
  logic             temp_sign;
  logic [ByteW-1:0] cnt_remain;
  logic [ByteW-1:0] cnt_per_deg;

  // A directed row arms a hand-written answer for the block it sends
  logic     typed_armed;
  reading_t typed_value;

  reading_t    pending_readings [$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int          send_calm;

  // Reflected CRC8 (polynomial 0x8C), bit-serial, LSB first
  function automatic logic [ByteW-1:0] crc_fold(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    logic             mix;
    c = crc;
    for (int k = 0; k < ByteW; k++) begin
      mix = c[0] ^ b[k];
      c   = {1'b0, c[ByteW-1:1]};
      if (mix) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Append the CRC of bytes 0..7 so the nine-byte remainder comes out zero
  function automatic logic [71:0] seal_block(input logic [63:0] body);
    logic [ByteW-1:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = crc_fold(c, body[63-8*k -: 8]);
    end
    return {body, c};
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one;
  // now and then a calm stretch with no pauses at all
  task automatic pick_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 60);
      gap  = 0;
    end else if (r < 50) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  // Advance the shadow decoder by one beat; on the ninth byte queue the reading
  task automatic decode_beat(input logic [ByteW-1:0] b);
    int       whole;
    int       diff;
    int       mag;
    int       frac;
    reading_t r;
    scratch_crc = crc_fold(scratch_crc, b);
    case (scratch_pos)
      PosTempLsb:  temp_half   = b;
      PosTempMsb:  temp_sign   = b[0];
      PosCountRem: cnt_remain  = b;
      PosCountPer: cnt_per_deg = b;
      default: ;
    endcase
    if (scratch_pos != PosLast) begin
      scratch_pos = scratch_pos + 1'b1;
    end else begin
      diff   = int'(cnt_per_deg) - int'(cnt_remain);
      r.temp = '0;
      if (scratch_crc != '0) begin
        r.status = ST_CRC_ERR;
      end else if (diff == 1) begin
        r.status = ST_NOT_READY;
      end else if (cnt_per_deg == '0) begin
        r.status = ST_CPC_ZERO;
      end else begin
        // magnitude divide, then restore the sign: truncation toward zero
        mag   = (diff < 0) ? -diff : diff;
        frac  = (mag * 256) / int'(cnt_per_deg);
        if (diff < 0) begin
          frac = -frac;
        end
        whole = int'(temp_half >> 1);
        if (temp_sign) begin
          whole = whole - 128;
        end
        r.status = ST_OK;
        r.temp   = TempW'(whole * 256 - 64 + frac);
      end
      if (typed_armed) begin
        r           = typed_value;
        typed_armed = 1'b0;
      end
      pending_readings.push_back(r);
      scratch_pos = '0;
      scratch_crc = '0;
    end
  endtask

  // Present one byte at the falling edge, hold it until a rising edge sees full low
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    pick_gap(send_calm, gap);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push        <= 1'b1;
    data_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (full);
    decode_beat(b);
    bytes_sent++;
  endtask

  task automatic drive_block(input logic [71:0] blk);
    for (int k = 0; k < 9; k++) begin
      send_byte(blk[71-8*k -: 8]);
    end
  endtask

  // Random block: well-formed with random content most of the time, with the
  // counts steered toward the interesting corners; the rest is corrupted or noise
  task automatic send_random_block();
    logic [63:0] body;
    logic [71:0] blk;
    logic [7:0]  cr;
    logic [7:0]  cpc;
    int          kind;
    int          n;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      body = {$urandom(), $urandom()};
      n    = $urandom_range(0, 9);
      if (n < 5) begin
        cpc = 8'h10;
        cr  = 8'($urandom_range(0, 8'h10));
      end else if (n == 5) begin
        cr  = 8'($urandom_range(0, 254));
        cpc = cr + 1'b1;
      end else if (n == 6) begin
        cr  = 8'($urandom_range(0, 255));
        cpc = '0;
      end else begin
        cr  = 8'($urandom_range(0, 255));
        cpc = 8'($urandom_range(0, 255));
      end
      body[15:0] = {cr, cpc};
      blk        = seal_block(body);
      if (kind >= 76) begin
        blk = blk ^ (72'h1 << $urandom_range(0, 71));
      end
      drive_block(blk);
    end else begin
      // stray bytes, then pad back to a block boundary
      n = $urandom_range(1, 20);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      while (scratch_pos != '0) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("unexpected reading: status %0d temp %0d", status_o, temperature_q8_o);
      end
    end else begin
      want = pending_readings.pop_front();
      if (status_o !== want.status || temperature_q8_o !== want.temp) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("reading mismatch: status exp %0d got %0d, temp exp %0d got %0d",
                   want.status, status_o, want.temp, temperature_q8_o);
        end
      end
    end
  endtask

  // Result side: pop with random stalls, check every beat taken
  initial begin : result_side
    int calm;
    int stall;
    calm  = 0;
    stall = 0;
    pop   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        pick_gap(calm, stall);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        check_reading();
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [71:0] blk;
    int          i;
    // known values on every input from time zero
    rst_ni      = 1'b0;
    push        = 1'b0;
    data_byte_i = '0;
    scratch_pos = '0;
    scratch_crc = '0;
    temp_half   = '0;
    temp_sign   = 1'b0;
    cnt_remain  = '0;
    cnt_per_deg = '0;
    typed_armed = 1'b0;
    typed_value = '0;
    mismatches  = 0;
    bytes_sent  = 0;
    send_calm   = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed blocks: extremes, every status, check order, negative fraction
    for (i = 0; i < DirRows; i++) begin
      blk = seal_block(dir_rows[i].body);
      if (dir_rows[i].bad_crc) begin
        blk = blk ^ (72'h1 << $urandom_range(0, 71));
      end
      typed_armed = dir_rows[i].typed;
      typed_value = '{dir_rows[i].status, dir_rows[i].temp};
      drive_block(blk);
    end

    // Random blocks until the byte budget is spent
    while (bytes_sent < ByteBudget) begin
      send_random_block();
    end
    @(negedge clk_i);
    push <= 1'b0;

    // Drain: every queued reading must come out, then nothing more may follow
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sctd_pkg.sv
rtl/sctd_front.sv
rtl/sctd_jobq.sv
rtl/sctd_back.sv
rtl/scratchpad_crc_temperature_decode.sv
rtl/sctd_checker.sv
dv/scratchpad_crc_temperature_decode_tb.sv
